/* rtl/sbbf_pkg.sv */
// Types, constants and salt table for the split-block Bloom filter.
// Self-contained; imported by sbbf_store and split_block_bloom_filter.
`timescale 1ns / 1ps

package sbbf_pkg;

   localparam int MAX_BLOCKS      = 1024;
   localparam int WORDS_PER_BLOCK = 8;
   localparam int WORD_W          = 32;
   localparam int BLK_AW          = $clog2(MAX_BLOCKS);
   localparam int LANE_W          = $clog2(WORDS_PER_BLOCK);
   localparam int WORD_AW         = BLK_AW + LANE_W;
   localparam int NB_W            = BLK_AW + 1;
   localparam int HASH_W          = 64;
   localparam int KEY_W           = 32;
   localparam int POS_SHIFT       = 27;

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_LOAD   = 2'd2;
   localparam logic [1:0] OP_READ   = 2'd3;

   localparam logic [WORDS_PER_BLOCK-1:0][KEY_W-1:0] SALT = {
      32'h5c6bfb31, 32'h9efc4947, 32'h2df1424b, 32'h705495c7,
      32'ha2b7289d, 32'h8824ad5b, 32'h44974d91, 32'h47b6137b
   };

   typedef struct packed {
      logic [1:0]         op;
      logic [HASH_W-1:0]  hash;
      logic [12:0]        word_index;
      logic [WORD_W-1:0]  word_data;
   } sbbf_req_type;

   typedef struct packed {
      logic              found;
      logic [WORD_W-1:0] read_data;
   } sbbf_rsp_type;

   // one access to the banked store: all lanes share the row address
   typedef struct packed {
      logic                                    rd_en;
      logic [BLK_AW-1:0]                       addr;
      logic [WORDS_PER_BLOCK-1:0]              wr_en;
      logic [WORDS_PER_BLOCK-1:0][WORD_W-1:0]  wr_data;
   } sbbf_mem_req_type;

endpackage

/* rtl/split_block_bloom_filter.sv */
// Split-block Bloom filter, top level: command port, config register, control.
// Depends on sbbf_pkg and sbbf_store.
// Each accepted item passes the calc, read and modify states; the result strobe is registered.
// Busy covers calc, read and modify states, so a new item is taken only after the last one leaves modify.
// Reset: synchronous; clears all filter words in a sweep over all 1024 rows, busy meanwhile.
// Results are strobed for one cycle; the receiver cannot stall them.
`timescale 1ns / 1ps

module split_block_bloom_filter (
   input  logic                         clock,
   input  logic                         reset,
   // command channel
   input  logic                         start,
   output logic                         busy,
   input  sbbf_pkg::sbbf_req_type       req_item,
   // result channel
   output logic                         rsp_valid,
   output sbbf_pkg::sbbf_rsp_type       rsp_item,
   // configuration: num_blocks
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [sbbf_pkg::NB_W-1:0]    csr_wdata
);
   import sbbf_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CALC = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_MOD  = 2'd3;

   localparam logic [NB_W-1:0] NB_MAX = NB_W'(MAX_BLOCKS);
   localparam int PROD_W = KEY_W + NB_W;

   logic [1:0]              st_ff, st_in;
   sbbf_req_type            req_ff;
   logic [BLK_AW-1:0]       row_ff, row_in;
   logic [WORDS_PER_BLOCK-1:0][WORD_W-1:0] mask_ff, mask_in;
   logic [NB_W-1:0]         nb_ff;
   logic                    clr_ff;
   logic [BLK_AW-1:0]       clr_cnt_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   sbbf_rsp_type            rsp_ff, rsp_in;

   logic                    accept;
   logic                    hash_op;
   logic [NB_W-1:0]         nb_eff;
   logic [PROD_W-1:0]       blk_prod;
   sbbf_mem_req_type        mem_req;
   logic [WORDS_PER_BLOCK-1:0][WORD_W-1:0] rd_data;
   logic [LANE_W-1:0]       lane_sel;

   // handshakes; config must be written only while idle (the block does not enforce this), so always ready
   assign busy      = clr_ff || (st_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign hash_op  = (req_ff.op == OP_INSERT) || (req_ff.op == OP_QUERY);
   assign lane_sel = req_ff.word_index[LANE_W-1:0];

   // blocks in use: zero acts as one, saturate at the store size
   always_comb begin
      priority if (nb_ff == '0) begin
         nb_eff = NB_W'(1);
      end else if (nb_ff > NB_MAX) begin
         nb_eff = NB_MAX;
      end else begin
         nb_eff = nb_ff;
      end
   end

   // block = (hash_hi * n) >> 32; result is below n, so BLK_AW bits suffice
   assign blk_prod = PROD_W'(req_ff.hash[HASH_W-1:KEY_W]) * PROD_W'(nb_eff);

   // row address and per-lane bit masks, registered in the calc state
   always_comb begin
      logic [KEY_W-1:0] prod;
      row_in = hash_op ? blk_prod[KEY_W +: BLK_AW] : req_ff.word_index[WORD_AW-1:LANE_W];
      for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
         prod       = req_ff.hash[KEY_W-1:0] * SALT[i];
         mask_in[i] = WORD_W'(1) << prod[KEY_W-1:POS_SHIFT];
      end
   end

   // store access: clear sweep, then read of one row per item, written back on insert (all lanes) or load (one lane)
   always_comb begin
      mem_req = '0;
      if (clr_ff) begin
         mem_req.addr  = clr_cnt_ff;
         mem_req.wr_en = '1;
      end else begin
         mem_req.addr = row_ff;
         unique case (st_ff)
            ST_READ: begin
               mem_req.rd_en = 1'b1;
            end
            ST_MOD: begin
               if (req_ff.op == OP_INSERT) begin
                  mem_req.wr_en = '1;
                  for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
                     mem_req.wr_data[i] = rd_data[i] | mask_ff[i];
                  end
               end else if (req_ff.op == OP_LOAD) begin
                  mem_req.wr_en[lane_sel] = 1'b1;
                  for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
                     mem_req.wr_data[i] = req_ff.word_data;
                  end
               end
            end
            ST_IDLE, ST_CALC: begin
            end
            default: begin
            end
         endcase
      end
   end

   // next state and result
   always_comb begin
      logic hit;
      hit          = 1'b1;
      st_in        = st_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      for (int i = 0; i < WORDS_PER_BLOCK; i++) begin
         if ((rd_data[i] & mask_ff[i]) == '0) begin
            hit = 1'b0;
         end
      end
      unique case (st_ff)
         ST_IDLE: begin
            if (accept) begin
               st_in = ST_CALC;
            end
         end
         ST_CALC: begin
            st_in = ST_READ;
         end
         ST_READ: begin
            st_in = ST_MOD;
         end
         ST_MOD: begin
            st_in        = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_in.found = (req_ff.op == OP_QUERY) && hit;
            if (req_ff.op == OP_READ) begin
               rsp_in.read_data = rd_data[lane_sel];
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         nb_ff        <= NB_MAX;
         clr_ff       <= 1'b1;
         clr_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            nb_ff <= csr_wdata;
         end
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + BLK_AW'(1);
            if (clr_cnt_ff == BLK_AW'(MAX_BLOCKS - 1)) begin
               clr_ff <= 1'b0;
            end
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
      if (st_ff == ST_CALC) begin
         row_ff  <= row_in;
         mask_ff <= mask_in;
      end
      rsp_ff <= rsp_in;
   end

   sbbf_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

`ifndef ASSERT_OFF
   a_rsp_after_mod: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(st_ff == ST_MOD))
      else $error("result strobe without a modify cycle");

   a_accept_calc: assert property (@(posedge clock) disable iff (reset)
      accept |=> st_ff == ST_CALC)
      else $error("accepted item did not enter calc");

   a_write_ok: assert property (@(posedge clock) disable iff (reset)
      (mem_req.wr_en != '0) |-> (clr_ff || st_ff == ST_MOD))
      else $error("store written outside clear or modify");

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      clr_ff |-> busy && !rsp_valid_in)
      else $error("activity during clear sweep");

   a_no_rw: assert property (@(posedge clock) disable iff (reset)
      mem_req.rd_en |-> (mem_req.wr_en == '0))
      else $error("read and write in the same cycle");
`endif

endmodule

/* rtl/sbbf_store.sv */
// Filter word store: one synchronous bank per word of a block.
// Depends on sbbf_pkg. Read data registered.
`timescale 1ns / 1ps

module sbbf_store (
   input  logic                                                    clock,
   input  sbbf_pkg::sbbf_mem_req_type                              mem_req,
   output logic [sbbf_pkg::WORDS_PER_BLOCK-1:0][sbbf_pkg::WORD_W-1:0] rd_data
);
   import sbbf_pkg::*;

   for (genvar g = 0; g < WORDS_PER_BLOCK; g++) begin : g_bank
      logic [WORD_W-1:0] bank_mem [MAX_BLOCKS];
      logic [WORD_W-1:0] rd_ff;

      always_ff @(posedge clock) begin
         if (mem_req.wr_en[g]) begin
            bank_mem[mem_req.addr] <= mem_req.wr_data[g];
         end
         if (mem_req.rd_en) begin
            rd_ff <= bank_mem[mem_req.addr];
         end
      end

      assign rd_data[g] = rd_ff;
   end

endmodule

/* tb/sv/tb.sv */
// Self-checking bench for split_block_bloom_filter: directed and random insert,
// query, load and read transfers, predicted by a behavioural filter model.
// Depends on sbbf_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
   import sbbf_pkg::*;

   localparam int STORE_WORDS = MAX_BLOCKS * WORDS_PER_BLOCK;
   localparam int CYCLE_LIMIT = 200000;  // far above the slowest correct run
   localparam int SETTLE_CYCLES = 8;
   localparam int PHASE_ITEMS = 155;
   localparam int NUM_PHASES = 6;
   localparam int RECENT_DEPTH = 32;

   // Published Parquet salts, lane 0 first
   localparam logic [31:0] LANE_SALT [WORDS_PER_BLOCK] = '{
      32'h47b6137b, 32'h44974d91, 32'h8824ad5b, 32'ha2b7289d,
      32'h705495c7, 32'h2df1424b, 32'h9efc4947, 32'h5c6bfb31
   };

   typedef struct {
      sbbf_req_type item;
      bit           drain_first;  // hold off until every result is back
   } pending_cmd_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   sbbf_req_type        req_item = '0;
   logic                rsp_valid;
   sbbf_rsp_type        rsp_item;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [NB_W-1:0]     csr_wdata = '0;

   // filter model state
   logic [31:0]         model_words [STORE_WORDS];
   logic [NB_W-1:0]     model_num_blocks;

   pending_cmd_type     pending_cmds [$];
   sbbf_rsp_type        expected_rsps [$];
   logic [63:0]         recent_hashes [$];
   logic [12:0]         recent_bases [$];

   int                  idle_pct = 0;
   int                  error_count = 0;
   int                  cycle_count = 0;
   int                  rsp_checked = 0;
   int                  n_insert = 0, n_query = 0, n_hits = 0, n_load = 0, n_read = 0;

   split_block_bloom_filter i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Filter model
   // ---------------------------------------------------------------------

   // Block index from the upper hash half, scaled by the blocks in use.
   // Zero blocks behaves as one; anything above the maximum saturates.
   function automatic logic [BLK_AW-1:0] filter_block(logic [63:0] hash);
      logic [NB_W-1:0] nb;
      logic [63:0]     prod;
      nb = model_num_blocks;
      if (nb == '0) nb = NB_W'(1);
      if (nb > NB_W'(MAX_BLOCKS)) nb = NB_W'(MAX_BLOCKS);
      prod = {32'b0, hash[63:32]} * {{(64-NB_W){1'b0}}, nb};
      return prod[32 +: BLK_AW];
   endfunction

   function automatic logic [31:0] lane_mask(logic [31:0] key, int lane);
      logic [31:0] prod;
      prod = key * LANE_SALT[lane];
      return 32'h1 << prod[31:27];
   endfunction

   // Applies one command to the model and returns the result it owes.
   function automatic sbbf_rsp_type predict_filter(sbbf_req_type r);
      sbbf_rsp_type res;
      logic [12:0]  base;
      logic [31:0]  mask;
      res = '0;
      base = {filter_block(r.hash), 3'b000};
      case (r.op)
         OP_INSERT: begin
            n_insert++;
            for (int lane = 0; lane < WORDS_PER_BLOCK; lane++) begin
               model_words[base + lane] |= lane_mask(r.hash[31:0], lane);
            end
         end
         OP_QUERY: begin
            n_query++;
            res.found = 1'b1;
            for (int lane = 0; lane < WORDS_PER_BLOCK; lane++) begin
               mask = lane_mask(r.hash[31:0], lane);
               if ((model_words[base + lane] & mask) == 0) res.found = 1'b0;
            end
            if (res.found) n_hits++;
         end
         OP_LOAD: begin
            n_load++;
            model_words[r.word_index] = r.word_data;
         end
         default: begin
            n_read++;
            res.read_data = model_words[r.word_index];
         end
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------

   task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
      if (error_count < 40) begin
         $display("[%0t] MISMATCH %s: expected 0x%08h, got 0x%08h", $realtime, what, want, got);
      end
      error_count++;
   endtask

   // Monitor: checks results first, then records the command accepted at
   // this edge, so neither depends on the order of the two always blocks.
   always @(posedge clock) begin
      sbbf_rsp_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("result with nothing outstanding", '0, rsp_item.read_data);
            end else begin
               want = expected_rsps.pop_front();
               rsp_checked++;
               if (rsp_item.found !== want.found) begin
                  report_mismatch("found", 32'(want.found), 32'(rsp_item.found));
               end
               if (rsp_item.read_data !== want.read_data) begin
                  report_mismatch("read_data", want.read_data, rsp_item.read_data);
               end
            end
         end
         if (start && !busy) begin
            expected_rsps.push_back(predict_filter(req_item));
         end
      end
   end

   // ---------------------------------------------------------------------
   // Driver
   // ---------------------------------------------------------------------

   // start stays high while a command waits on busy; a new command may
   // follow an accepted one with no gap. One NBA per signal per edge.
   always @(posedge clock) begin
      bit              accepted;
      bit              launch;
      pending_cmd_type nxt;
      accepted = start && !busy;
      launch = 1'b0;
      if (!start || accepted) begin
         if (!reset && pending_cmds.size() > 0) begin
            if (pending_cmds[0].drain_first) begin
               launch = (expected_rsps.size() == 0) && !accepted;
            end else begin
               launch = ($urandom_range(99) >= idle_pct);
            end
         end
         if (launch) begin
            nxt = pending_cmds.pop_front();
            req_item <= nxt.item;
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[%0t] timeout after %0d cycles", $realtime, cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------

   task automatic queue_cmd(logic [1:0] op, logic [63:0] hash, logic [12:0] idx,
                            logic [31:0] data, bit drain = 1'b0);
      pending_cmd_type c;
      c.item.op = op;
      c.item.hash = hash;
      c.item.word_index = idx;
      c.item.word_data = data;
      c.drain_first = drain;
      pending_cmds.push_back(c);
   endtask

   // Block is idle: nothing queued, nothing in flight, not clearing.
   // Sampled mid-cycle so every update of the last edge has settled.
   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || start || expected_rsps.size() != 0 || busy);
      @(posedge clock);
   endtask

   task automatic write_num_blocks(logic [NB_W-1:0] value);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      model_num_blocks = value;
      recent_hashes.delete();
      recent_bases.delete();
   endtask

   function automatic logic [63:0] rand_hash();
      return {$urandom, $urandom};
   endfunction

   // Mostly well-formed traffic: inserts followed by queries of the same
   // hashes, word accesses aimed at blocks just touched, plus some noise.
   task automatic queue_random_cmd(bit drain);
      logic [1:0]  op;
      logic [63:0] hash;
      logic [12:0] idx;
      logic [31:0] data;
      int          pick;
      op = 2'($urandom_range(3));
      hash = rand_hash();
      idx = 13'($urandom_range(STORE_WORDS - 1));
      data = $urandom;
      pick = $urandom_range(99);
      if (pick < 30) begin
         op = OP_INSERT;
         recent_hashes.push_back(hash);
         recent_bases.push_back({filter_block(hash), 3'b000});
         if (recent_hashes.size() > RECENT_DEPTH) begin
            void'(recent_hashes.pop_front());
            void'(recent_bases.pop_front());
         end
      end else if (pick < 55) begin
         op = OP_QUERY;
         if (recent_hashes.size() > 0) begin
            hash = recent_hashes[$urandom_range(recent_hashes.size() - 1)];
         end
      end else if (pick < 65) begin
         op = OP_QUERY;
      end else if (pick < 90) begin
         op = (pick < 75) ? OP_LOAD : OP_READ;
         if (recent_bases.size() > 0 && $urandom_range(1)) begin
            idx = recent_bases[$urandom_range(recent_bases.size() - 1)] +
                  13'($urandom_range(WORDS_PER_BLOCK - 1));
         end
         case ($urandom_range(7))
            0: data = '0;
            1: data = '1;
            default: ;
         endcase
      end
      // remaining share: fully random noise
      queue_cmd(op, hash, idx, data, drain);
   endtask

   logic [NB_W-1:0] phase_nb   [NUM_PHASES];
   int              phase_idle [NUM_PHASES];

   initial begin
      for (int w = 0; w < STORE_WORDS; w++) model_words[w] = '0;
      model_num_blocks = NB_W'(MAX_BLOCKS);
      phase_nb   = '{NB_W'(MAX_BLOCKS), '0, NB_W'(2047), NB_W'(1),
                     NB_W'(MAX_BLOCKS + 1), '0};
      phase_nb[5] = NB_W'($urandom_range(MAX_BLOCKS - 1, 2));
      phase_idle = '{0, 53, 0, 37, 53, 37};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset block count: extremes of hash and word
      // index, every op, clearing a word that a query relies on.
      queue_cmd(OP_INSERT, 64'h0, 13'h1fff, 32'hffff_ffff);
      queue_cmd(OP_QUERY,  64'h0, 13'h0, 32'h0);
      queue_cmd(OP_INSERT, 64'hffff_ffff_ffff_ffff, 13'h0, 32'h0);
      queue_cmd(OP_QUERY,  64'hffff_ffff_ffff_ffff, 13'h1fff, 32'hffff_ffff);
      queue_cmd(OP_QUERY,  64'hffff_ffff_0000_0000, 13'h0, 32'h0);
      queue_cmd(OP_READ,   64'hffff_ffff_ffff_ffff, 13'h0, 32'hffff_ffff);
      queue_cmd(OP_READ,   64'h0, 13'h1fff, 32'h0);
      queue_cmd(OP_LOAD,   64'h0, 13'h0, 32'hffff_ffff);
      queue_cmd(OP_LOAD,   64'hffff_ffff_ffff_ffff, 13'h1fff, 32'h0);
      queue_cmd(OP_READ,   64'h0, 13'h0, 32'h0);
      queue_cmd(OP_READ,   64'h0, 13'h1fff, 32'h0);
      queue_cmd(OP_QUERY,  64'hffff_ffff_ffff_ffff, 13'h0, 32'h0);
      queue_cmd(OP_LOAD,   64'h0, 13'h1fff, 32'hffff_ffff);
      queue_cmd(OP_QUERY,  64'hffff_ffff_ffff_ffff, 13'h0, 32'h0);
      queue_cmd(OP_READ,   64'h0, 13'h1000, 32'h0);
      queue_cmd(OP_LOAD,   64'h0, 13'h0001, 32'ha5a5_a5a5);
      queue_cmd(OP_READ,   64'h0, 13'h0001, 32'h5a5a_5a5a);
      queue_cmd(OP_INSERT, 64'h8000_0000_1234_5678, 13'h0, 32'h0);
      queue_cmd(OP_QUERY,  64'h8000_0000_1234_5678, 13'h0, 32'h0);
      queue_cmd(OP_READ,   64'h0, 13'h1000, 32'h0);
      queue_cmd(OP_QUERY,  64'h8000_0000_1234_5679, 13'h0, 32'h0);

      // Random phases, each at its own block count and sender idle rate;
      // two of them pause mid-stream until the pipeline has drained.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_quiet();
         write_num_blocks(phase_nb[ph]);
         idle_pct = phase_idle[ph];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            queue_random_cmd((ph == 1 || ph == 4) && n == PHASE_ITEMS / 2);
         end
      end

      wait_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         report_mismatch("results never returned", 32'(expected_rsps.size()), '0);
      end

      $display("Covered %0d transfers: %0d inserts, %0d queries (%0d hits), %0d loads, %0d reads",
               rsp_checked, n_insert, n_query, n_hits, n_load, n_read);
      $display("Block counts 0, 1, %0d, %0d, %0d and 2047; sender idle 0, 37 and 53 percent",
               phase_nb[5], MAX_BLOCKS, MAX_BLOCKS + 1);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
